### design/rbap_pkg.sv
package rbap_pkg;

  // limits of the parser, used as defaults of the top level parameters
  localparam int MAX_TOKEN_LEN_DEF = 4096;
  localparam int MAX_TOKENS_DEF    = 16;

  // protocol characters
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  typedef enum logic [1:0] {
    KIND_PAYLOAD   = 2'd0,
    KIND_EMPTY_TOK = 2'd1,
    KIND_EMPTY_REQ = 2'd2,
    KIND_ERROR     = 2'd3
  } kind_t;

  typedef struct packed {
    logic       start_of_request;
    logic [7:0] data_byte;
  } req_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] payload_byte;
    logic [3:0] token_number;
    logic       token_last;
    logic       request_last;
  } res_t;

  // what the parser produces for one consumed byte
  typedef struct packed {
    logic valid;
    res_t res;
  } outcome_t;

endpackage

### design/rbap_skid.sv
module rbap_skid
  import rbap_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic up_valid,
  input  req_t up_item,
  output logic up_stall,
  output logic dn_valid,
  output req_t dn_item,
  input  logic dn_take
);

  logic main_valid;
  req_t main_item;
  logic spare_valid;
  req_t spare_item;
  logic up_accept;

  assign up_accept = up_valid && !spare_valid;
  assign up_stall  = spare_valid;
  assign dn_valid  = main_valid;
  assign dn_item   = main_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid  <= 1'b0;
      spare_valid <= 1'b0;
    end else if (dn_take || !main_valid) begin
      if (spare_valid) begin
        main_valid  <= 1'b1;
        spare_valid <= 1'b0;
      end else begin
        main_valid <= up_accept;
      end
    end else if (up_accept) begin
      spare_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (dn_take || !main_valid) begin
      if (spare_valid) begin
        main_item <= spare_item;
      end else if (up_accept) begin
        main_item <= up_item;
      end
    end else if (up_accept) begin
      spare_item <= up_item;
    end
  end

`ifndef SYNTHESIS
  // the spare slot only fills behind a held main slot
  a_spare_needs_main: assert property (@(posedge clk) disable iff (rst)
    spare_valid |-> main_valid)
    else $error("spare slot full while main slot empty");
`endif

endmodule

### design/rbap_parse.sv
module rbap_parse
  import rbap_pkg::*;
#(
  parameter int MAX_TOKEN_LEN = MAX_TOKEN_LEN_DEF,
  parameter int MAX_TOKENS    = MAX_TOKENS_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     advance,
  input  req_t     item,
  output outcome_t outcome
);

  localparam int LenW = $clog2(MAX_TOKEN_LEN + 1);
  localparam int CntW = $clog2(MAX_TOKENS + 1);
  localparam int AccW = (LenW > CntW) ? LenW : CntW;
  localparam int MulW = AccW + 4;

  typedef enum logic [7:0] {
    PH_IDLE   = 8'b0000_0001,
    PH_NFIRST = 8'b0000_0010,
    PH_NREQ   = 8'b0000_0100,
    PH_NDIGS  = 8'b0000_1000,
    PH_NLF    = 8'b0001_0000,
    PH_HEAD   = 8'b0010_0000,
    PH_DATA   = 8'b0100_0000,
    PH_SKIP   = 8'b1000_0000
  } phase_t;

  phase_t            phase, phase_next;
  logic              is_len, is_len_next;
  logic [AccW-1:0]   acc, acc_next;
  logic              neg, neg_next;
  logic [CntW-1:0]   tokens_left, tokens_left_next;
  logic [3:0]        token_counter, token_counter_next;
  logic [LenW-1:0]   payload_left, payload_left_next;
  logic              skip_first, skip_first_next;

  logic [7:0]        b;
  logic              is_digit;
  logic [3:0]        dval;
  logic [AccW-1:0]   acc_base;
  logic [MulW-1:0]   acc_new;
  logic [MulW-1:0]   lim;
  logic              over;
  logic              bad;
  logic              num_done;
  logic              tok_done;
  logic              tl;

  assign b        = item.data_byte;
  assign is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
  assign dval     = 4'(b - CH_ZERO);
  assign acc_base = (phase == PH_NDIGS) ? acc : '0;
  assign acc_new  = MulW'(acc_base) * MulW'(10) + MulW'(dval);
  assign lim      = is_len ? MulW'(MAX_TOKEN_LEN) : MulW'(MAX_TOKENS);
  assign over     = acc_new > lim;

  always_comb begin
    phase_next         = phase;
    is_len_next        = is_len;
    acc_next           = acc;
    neg_next           = neg;
    tokens_left_next   = tokens_left;
    token_counter_next = token_counter;
    payload_left_next  = payload_left;
    skip_first_next    = skip_first;
    outcome            = '0;
    bad                = 1'b0;
    num_done           = 1'b0;
    tok_done           = 1'b0;
    tl                 = 1'b0;

    if (item.start_of_request) begin
      // a start flag always drops whatever parse was running
      tokens_left_next   = '0;
      token_counter_next = '0;
      payload_left_next  = '0;
      skip_first_next    = 1'b0;
      acc_next           = '0;
      neg_next           = 1'b0;
      is_len_next        = 1'b0;
      if (b == CH_STAR) begin
        phase_next = PH_NFIRST;
      end else begin
        phase_next           = PH_IDLE;
        outcome.valid        = 1'b1;
        outcome.res.kind     = KIND_ERROR;
      end
    end else begin
      unique case (phase)
        PH_IDLE: begin
        end
        PH_NFIRST, PH_NREQ: begin
          if (phase == PH_NFIRST && (b == CH_PLUS || b == CH_MINUS)) begin
            neg_next   = (b == CH_MINUS);
            phase_next = PH_NREQ;
          end else if (!is_digit) begin
            bad = 1'b1;
          end else begin
            acc_next   = AccW'(acc_new);
            phase_next = PH_NDIGS;
            bad        = over;
          end
        end
        PH_NDIGS: begin
          if (is_digit) begin
            acc_next = AccW'(acc_new);
            bad      = over;
          end else if (b == CH_CR) begin
            // only minus zero is a legal negative number
            if (neg && acc != '0) begin
              bad = 1'b1;
            end else begin
              phase_next = PH_NLF;
            end
          end else begin
            bad = 1'b1;
          end
        end
        PH_NLF: begin
          if (b == CH_LF) begin
            num_done = 1'b1;
          end else begin
            bad = 1'b1;
          end
        end
        PH_HEAD: begin
          if (b == CH_DOLLAR) begin
            acc_next    = '0;
            neg_next    = 1'b0;
            is_len_next = 1'b1;
            phase_next  = PH_NFIRST;
          end else begin
            phase_next = PH_IDLE;
          end
        end
        PH_DATA: begin
          tl                       = payload_left <= LenW'(1);
          outcome.valid            = 1'b1;
          outcome.res.kind         = KIND_PAYLOAD;
          outcome.res.payload_byte = b;
          outcome.res.token_number = token_counter;
          outcome.res.token_last   = tl;
          outcome.res.request_last = tl && (tokens_left == CntW'(1));
          if (payload_left != '0) begin
            payload_left_next = payload_left - LenW'(1);
          end
          tok_done = tl;
        end
        PH_SKIP: begin
          if (skip_first) begin
            skip_first_next = 1'b0;
          end else begin
            phase_next = (tokens_left == '0) ? PH_IDLE : PH_HEAD;
          end
        end
        default: begin
          phase_next = PH_IDLE;
        end
      endcase

      if (bad) begin
        phase_next               = PH_IDLE;
        outcome.valid            = 1'b1;
        outcome.res.kind         = KIND_ERROR;
        outcome.res.token_number = token_counter;
      end

      if (num_done) begin
        if (!is_len) begin
          token_counter_next = '0;
          tokens_left_next   = CntW'(acc);
          if (acc == '0) begin
            phase_next               = PH_IDLE;
            outcome.valid            = 1'b1;
            outcome.res.kind         = KIND_EMPTY_REQ;
            outcome.res.request_last = 1'b1;
          end else begin
            phase_next = PH_HEAD;
          end
        end else if (acc == '0) begin
          outcome.valid            = 1'b1;
          outcome.res.kind         = KIND_EMPTY_TOK;
          outcome.res.token_number = token_counter;
          outcome.res.token_last   = 1'b1;
          outcome.res.request_last = (tokens_left == CntW'(1));
          tok_done                 = 1'b1;
        end else begin
          payload_left_next = LenW'(acc);
          phase_next        = PH_DATA;
        end
      end

      // end of a token: two trailing bytes follow
      if (tok_done) begin
        if (tokens_left != '0) begin
          tokens_left_next = tokens_left - CntW'(1);
        end
        token_counter_next = token_counter + 4'd1;
        skip_first_next    = 1'b1;
        phase_next         = PH_SKIP;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      is_len        <= 1'b0;
      acc           <= '0;
      neg           <= 1'b0;
      tokens_left   <= '0;
      token_counter <= '0;
      payload_left  <= '0;
      skip_first    <= 1'b0;
    end else if (advance) begin
      phase         <= phase_next;
      is_len        <= is_len_next;
      acc           <= acc_next;
      neg           <= neg_next;
      tokens_left   <= tokens_left_next;
      token_counter <= token_counter_next;
      payload_left  <= payload_left_next;
      skip_first    <= skip_first_next;
    end
  end

`ifndef SYNTHESIS
  a_data_has_bytes: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_DATA) |-> (payload_left != '0))
    else $error("payload phase with no bytes left");

  a_tokens_in_range: assert property (@(posedge clk) disable iff (rst)
    tokens_left <= CntW'(MAX_TOKENS))
    else $error("token count above limit");
`endif

endmodule

### design/resp_bulk_array_parser_top.sv
// request parser for an array of bulk strings, one byte per transaction
//
// req channel: req_item carries one request byte and a start flag that marks
//   the first byte of a request; a transaction completes when req_valid is
//   high and req_stall is low
// res channel: res_item carries one result (payload byte, empty-token marker,
//   empty-request marker or format error) with token index and last marks;
//   a byte gives at most one result, many give none
// throughput: one byte per cycle while res_stall is low; the parse state
//   is updated by a single pass of logic between the input slot and the
//   result register; an accepted byte waits in the input slot, is parsed
//   there, and its result is registered and offered on res
// stalls: while res_stall holds a result, the parser stops; the input skid
//   buffer fills its free slots and then raises req_stall (a registered
//   signal, so no combinational path joins the two stall inputs)
// reset: rst is synchronous; it empties both buffers and returns the parser
//   to idle, where bytes without a start flag are ignored
module resp_bulk_array_parser_top
  import rbap_pkg::*;
#(
  parameter int MAX_TOKEN_LEN = MAX_TOKEN_LEN_DEF,
  parameter int MAX_TOKENS    = MAX_TOKENS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  input  req_t req_item,
  output logic req_stall,
  output logic res_valid,
  output res_t res_item,
  input  logic res_stall
);

  logic     core_valid;
  req_t     core_item;
  logic     advance;
  outcome_t outcome;

  // input slot plus one spare entry
  rbap_skid u_skid (
    .clk      (clk),
    .rst      (rst),
    .up_valid (req_valid),
    .up_item  (req_item),
    .up_stall (req_stall),
    .dn_valid (core_valid),
    .dn_item  (core_item),
    .dn_take  (advance)
  );

  // parse one byte whenever the result register is free or being emptied
  assign advance = core_valid && (!res_valid || !res_stall);

  rbap_parse #(
    .MAX_TOKEN_LEN (MAX_TOKEN_LEN),
    .MAX_TOKENS    (MAX_TOKENS)
  ) u_parse (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .item    (core_item),
    .outcome (outcome)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= outcome.valid;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && outcome.valid) begin
      res_item <= outcome.res;
    end
  end

`ifndef SYNTHESIS
  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    (advance && outcome.valid) |=> res_valid)
    else $error("parsed result not presented");
`endif

endmodule

### dv/tb_resp_bulk_array_parser_top.sv
`timescale 1ns / 100ps

module tb_resp_bulk_array_parser_top;
  import rbap_pkg::*;

  // run shape
  localparam int unsigned RANDOM_ITEMS   = 750;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES   = 16;

  // parse phases of the mirror: each number takes four phases
  // (sign or first digit, digit required, more digits, LF expected)
  localparam logic [3:0] P_IDLE = 4'd0;
  localparam logic [3:0] P_CNT  = 4'd1;
  localparam logic [3:0] P_HEAD = 4'd5;
  localparam logic [3:0] P_LEN  = 4'd6;
  localparam logic [3:0] P_DATA = 4'd10;
  localparam logic [3:0] P_SKIP = 4'd11;

  localparam logic [3:0] OFS_SIGN   = 4'd0;
  localparam logic [3:0] OFS_FIRST  = 4'd1;
  localparam logic [3:0] OFS_DIGITS = 4'd2;
  localparam logic [3:0] OFS_LF     = 4'd3;

  localparam logic [7:0] CH_SPACE = 8'h20;

  // bytes that tend to land on a parser decision when dropped into a request
  localparam logic [7:0] ODD_CHARS [8] = '{CH_SPACE, CH_MINUS, CH_PLUS, CH_CR,
                                           CH_LF, CH_DOLLAR, CH_STAR, CH_ZERO};

  typedef enum logic [1:0] {NUM_MORE, NUM_BAD, NUM_DONE} num_st_t;

  // a result typed in by hand for a directed byte; typed low means the
  // predictor decides
  typedef struct packed {
    logic typed;
    logic fires;
    res_t res;
  } hand_check_t;

  typedef struct packed {
    req_t        item;
    hand_check_t chk;
  } vec_t;

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  req_t req_item  = '0;
  logic req_stall;
  logic res_valid;
  res_t res_item;
  logic res_stall = 1'b0;

  always #5 clk = ~clk;

  resp_bulk_array_parser_top DUT (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_item (req_item),
    .req_stall(req_stall),
    .res_valid(res_valid),
    .res_item (res_item),
    .res_stall(res_stall)
  );

  // ---------------------------------------------------------------------
  // parser state mirror, at reset values from the start
  // ---------------------------------------------------------------------
  logic [3:0]  ps_phase    = P_IDLE;
  int unsigned ps_acc      = 0;
  logic        ps_neg      = 1'b0;
  logic [4:0]  ps_left_tok = '0;
  logic [3:0]  ps_tok      = '0;
  logic [12:0] ps_left_pay = '0;
  logic [1:0]  ps_skip     = '0;

  res_t        pending_results [$];  // results owed by the block, oldest first
  hand_check_t hand_checks [$];      // one per byte offered, popped on acceptance
  vec_t        directed_q [$];
  req_t        burst_q [$];          // bytes of the request being composed
  int unsigned mismatches     = 0;
  int unsigned stalled_cycles = 0;
  logic        calm_tx        = 1'b0;  // sender runs back to back while set
  logic        calm_rx        = 1'b0;  // receiver never stalls while set

  function automatic outcome_t mark(kind_t k, logic [7:0] pb, logic [3:0] tn,
                                    logic tl, logic rl);
    outcome_t o;
    o.valid            = 1'b1;
    o.res.kind         = k;
    o.res.payload_byte = pb;
    o.res.token_number = tn;
    o.res.token_last   = tl;
    o.res.request_last = rl;
    return o;
  endfunction

  // one byte of a decimal number: optional sign, digits, CR, LF
  function automatic num_st_t scan_number(logic [3:0] base, int unsigned limit,
                                          logic [7:0] b);
    logic [3:0]  rel;
    logic        is_digit;
    int unsigned d;
    rel      = ps_phase - base;
    is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
    d        = 32'(b - CH_ZERO);
    if (rel == OFS_SIGN) begin
      if (b == CH_MINUS || b == CH_PLUS) begin
        ps_neg   = (b == CH_MINUS);
        ps_phase = base + OFS_FIRST;
        return NUM_MORE;
      end
      rel = OFS_FIRST;
    end
    if (rel == OFS_FIRST) begin
      if (!is_digit) return NUM_BAD;
      ps_acc   = d;
      ps_phase = base + OFS_DIGITS;
      return (ps_acc > limit) ? NUM_BAD : NUM_MORE;
    end
    if (rel == OFS_DIGITS) begin
      if (is_digit) begin
        ps_acc = ps_acc * 10 + d;
        return (ps_acc > limit) ? NUM_BAD : NUM_MORE;
      end
      if (b == CH_CR) begin
        // minus zero is fine, any other negative value fails here
        if (ps_neg && ps_acc != 0) return NUM_BAD;
        ps_phase = base + OFS_LF;
        return NUM_MORE;
      end
      return NUM_BAD;
    end
    return (b == CH_LF) ? NUM_DONE : NUM_BAD;
  endfunction

  function automatic void close_token();
    if (ps_left_tok > 0) ps_left_tok--;
    ps_tok   = ps_tok + 4'd1;
    ps_skip  = 2'd2;
    ps_phase = P_SKIP;
  endfunction

  // result caused by one accepted request byte, if any
  function automatic outcome_t parse_byte(req_t it);
    outcome_t   o;
    num_st_t    st;
    logic       tl;
    logic [7:0] b;
    o = '0;
    b = it.data_byte;
    if (it.start_of_request) begin
      // a start flag drops whatever was in progress
      ps_acc      = 0;
      ps_neg      = 1'b0;
      ps_left_tok = '0;
      ps_tok      = '0;
      ps_left_pay = '0;
      ps_skip     = '0;
      ps_phase    = P_IDLE;
      if (b != CH_STAR) o = mark(KIND_ERROR, 8'h00, 4'd0, 1'b0, 1'b0);
      else ps_phase = P_CNT;
    end else if (ps_phase >= P_CNT && ps_phase < P_HEAD) begin
      st = scan_number(P_CNT, MAX_TOKENS_DEF, b);
      if (st == NUM_BAD) begin
        ps_phase = P_IDLE;
        o        = mark(KIND_ERROR, 8'h00, 4'd0, 1'b0, 1'b0);
      end else if (st == NUM_DONE) begin
        ps_tok      = '0;
        ps_left_tok = ps_acc[4:0];
        if (ps_acc == 0) begin
          ps_phase = P_IDLE;
          o        = mark(KIND_EMPTY_REQ, 8'h00, 4'd0, 1'b0, 1'b1);
        end else begin
          ps_phase = P_HEAD;
        end
      end
    end else if (ps_phase == P_HEAD) begin
      // anything but a bulk string header silences the rest of the request
      if (b == CH_DOLLAR) begin
        ps_acc   = 0;
        ps_neg   = 1'b0;
        ps_phase = P_LEN;
      end else begin
        ps_phase = P_IDLE;
      end
    end else if (ps_phase >= P_LEN && ps_phase < P_DATA) begin
      st = scan_number(P_LEN, MAX_TOKEN_LEN_DEF, b);
      if (st == NUM_BAD) begin
        ps_phase = P_IDLE;
        o        = mark(KIND_ERROR, 8'h00, ps_tok, 1'b0, 1'b0);
      end else if (st == NUM_DONE) begin
        if (ps_acc == 0) begin
          o = mark(KIND_EMPTY_TOK, 8'h00, ps_tok, 1'b1, ps_left_tok == 5'd1);
          close_token();
        end else begin
          ps_left_pay = ps_acc[12:0];
          ps_phase    = P_DATA;
        end
      end
    end else if (ps_phase == P_DATA) begin
      tl = (ps_left_pay <= 13'd1);
      o  = mark(KIND_PAYLOAD, b, ps_tok, tl, tl && ps_left_tok == 5'd1);
      if (ps_left_pay > 0) ps_left_pay--;
      if (tl) close_token();
    end else if (ps_phase == P_SKIP) begin
      // two trailing bytes per token, taken without a look
      if (ps_skip > 0) ps_skip--;
      if (ps_skip == 0) ps_phase = (ps_left_tok == 0) ? P_IDLE : P_HEAD;
    end else begin
      ps_phase = P_IDLE;
    end
    return o;
  endfunction

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // ---------------------------------------------------------------------
  // scoreboard: predict on every accepted byte, check every accepted result,
  // and watch for a run that stops moving
  // ---------------------------------------------------------------------
  always @(posedge clk) begin : scoreboard
    hand_check_t hc;
    outcome_t    guess;
    res_t        want;
    logic        moved;
    moved = 1'b0;
    if (!rst) begin
      if (req_valid && !req_stall) begin
        hc    = hand_checks.pop_front();
        guess = parse_byte(req_item);
        // the predictor still runs on hand-typed rows to keep its state
        if (hc.typed) guess = {hc.fires, hc.res};
        if (guess.valid) pending_results.insert(pending_results.size(), guess.res);
        moved = 1'b1;
      end
      if (res_valid && !res_stall) begin
        if (pending_results.size() == 0) begin
          $display("%0t: result with none expected, actual kind %0d byte %0h token %0d",
                   $time, res_item.kind, res_item.payload_byte, res_item.token_number);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          check_field("kind", 8'(want.kind), 8'(res_item.kind));
          check_field("payload_byte", want.payload_byte, res_item.payload_byte);
          check_field("token_number", 8'(want.token_number), 8'(res_item.token_number));
          check_field("token_last", 8'(want.token_last), 8'(res_item.token_last));
          check_field("request_last", 8'(want.request_last), 8'(res_item.request_last));
        end
        moved = 1'b1;
      end
      stalled_cycles = moved ? 0 : stalled_cycles + 1;
      if (stalled_cycles >= WATCHDOG_LIMIT) begin
        $display("FAIL resp_bulk_array_parser_top");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------
  // result side: sometimes stall ahead of each transaction,
  // with calm stretches where it never stalls
  // ---------------------------------------------------------------------
  initial begin : result_sink
    int unsigned hold;
    do @(posedge clk); while (rst);
    forever begin
      if ($urandom_range(0, 19) == 0) calm_rx = ~calm_rx;
      hold = calm_rx ? 0 : $urandom_range(0, 10);
      if (hold != 0) begin
        res_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      res_stall <= 1'b0;
      do @(posedge clk); while (!(res_valid && !res_stall));
    end
  end

  // ---------------------------------------------------------------------
  // request side
  // ---------------------------------------------------------------------

  // offer one byte after a random gap and return on the edge that takes it;
  // valid stays high across back to back transactions
  task automatic send_byte(req_t it, hand_check_t chk);
    int unsigned gap;
    gap = calm_tx ? 0 : $urandom_range(0, 10);
    if (gap != 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    hand_checks.insert(hand_checks.size(), chk);
    req_valid <= 1'b1;
    req_item  <= it;
    do @(posedge clk); while (req_stall);
  endtask

  function automatic void row(logic s, logic [7:0] b);
    vec_t v;
    v = '{'{s, b}, '0};
    directed_q.insert(directed_q.size(), v);
  endfunction

  function automatic void row_chk(logic s, logic [7:0] b, logic fires, res_t r);
    vec_t v;
    v = '{'{s, b}, '{1'b1, fires, r}};
    directed_q.insert(directed_q.size(), v);
  endfunction

  function automatic void add_byte(logic s, logic [7:0] b);
    req_t it;
    it = '{s, b};
    burst_q.insert(burst_q.size(), it);
  endfunction

  // decimal number with CR LF, sometimes signed or zero padded
  function automatic void add_number(int unsigned v);
    string       digits;
    int unsigned style;
    style  = $urandom_range(0, 39);
    digits = $sformatf("%0d", v);
    if (style == 0) add_byte(1'b0, CH_PLUS);
    else if (style == 1) add_byte(1'b0, CH_ZERO);
    else if (style == 2 || (v == 0 && style < 6)) add_byte(1'b0, CH_MINUS);
    for (int i = 0; i < digits.len(); i++) add_byte(1'b0, digits[i]);
    add_byte(1'b0, CH_CR);
    add_byte(1'b0, CH_LF);
  endfunction

  // one request: mostly well formed with random content, a quarter broken
  function automatic void compose_request();
    int unsigned pick;
    int unsigned n_tok;
    int unsigned n_body;
    int unsigned len;
    int unsigned cut_at;
    req_t        fix;
    burst_q.delete();
    pick = $urandom_range(0, 99);
    if (pick < 5) n_tok = 0;
    else if (pick < 80) n_tok = $urandom_range(1, 4);
    else if (pick < 92) n_tok = $urandom_range(5, MAX_TOKENS_DEF - 1);
    else if (pick < 96) n_tok = MAX_TOKENS_DEF;
    else n_tok = $urandom_range(MAX_TOKENS_DEF + 1, 40);
    n_body = (n_tok > MAX_TOKENS_DEF) ? 0 : n_tok;
    add_byte(1'b1, CH_STAR);
    add_number(n_tok);
    for (int t = 0; t < n_body; t++) begin
      pick = $urandom_range(0, 99);
      if (pick < 15) len = 0;
      else if (pick < 85) len = $urandom_range(1, 8);
      else if (pick < 95) len = $urandom_range(9, 40);
      else if (pick < 98) len = MAX_TOKEN_LEN_DEF;
      else len = $urandom_range(MAX_TOKEN_LEN_DEF + 1, 9999);
      add_byte(1'b0, CH_DOLLAR);
      add_number(len);
      // a longest token is cut short by the next start; an oversize one
      // fails on its digits
      if (len > 40) begin
        repeat ($urandom_range(0, 3)) add_byte(1'b0, 8'($urandom_range(0, 255)));
        break;
      end
      repeat (len) add_byte(1'b0, 8'($urandom_range(0, 255)));
      if ($urandom_range(0, 9) != 0) begin
        add_byte(1'b0, CH_CR);
        add_byte(1'b0, CH_LF);
      end else begin
        add_byte(1'b0, 8'($urandom_range(0, 255)));
        add_byte(1'b0, 8'($urandom_range(0, 255)));
      end
    end
    // bytes past the end of a complete request are dropped by the block
    if ($urandom_range(0, 9) == 0)
      repeat ($urandom_range(1, 3)) add_byte(1'b0, 8'($urandom_range(0, 255)));
    if ($urandom_range(0, 3) == 0) begin
      cut_at = $urandom_range(0, burst_q.size() - 1);
      fix    = burst_q[cut_at];
      case ($urandom_range(0, 3))
        0: fix.data_byte = 8'($urandom_range(0, 255));
        1: fix.data_byte = ODD_CHARS[3'($urandom_range(0, 7))];
        2: if (cut_at > 0) burst_q = burst_q[0:cut_at-1];
        default: fix.start_of_request = 1'b1;
      endcase
      if (cut_at < burst_q.size()) burst_q[cut_at] = fix;
    end
  endfunction

  initial begin : stimulus
    int unsigned random_bytes;
    random_bytes = 0;

    // directed rows: idle noise, bad first byte, minus zero count, plus sign,
    // empty token, unchecked trailer, negative length, count over the limit,
    // CR without LF, and a token header that is not a bulk string
    row_chk(1'b0, "A", 1'b0, '0);
    row_chk(1'b1, "x", 1'b1, '{KIND_ERROR, 8'h00, 4'd0, 1'b0, 1'b0});
    row(1'b1, CH_STAR);
    row(1'b0, CH_MINUS);
    row(1'b0, CH_ZERO);
    row(1'b0, CH_CR);
    row_chk(1'b0, CH_LF, 1'b1, '{KIND_EMPTY_REQ, 8'h00, 4'd0, 1'b0, 1'b1});
    row(1'b1, CH_STAR);
    row(1'b0, CH_PLUS);
    row(1'b0, "2");
    row(1'b0, CH_CR);
    row(1'b0, CH_LF);
    row(1'b0, CH_DOLLAR);
    row(1'b0, CH_ZERO);
    row(1'b0, CH_CR);
    row_chk(1'b0, CH_LF, 1'b1, '{KIND_EMPTY_TOK, 8'h00, 4'd0, 1'b1, 1'b0});
    row(1'b0, 8'hFF);
    row(1'b0, 8'h00);
    row(1'b0, CH_DOLLAR);
    row(1'b0, CH_MINUS);
    row(1'b0, "1");
    row_chk(1'b0, CH_CR, 1'b1, '{KIND_ERROR, 8'h00, 4'd1, 1'b0, 1'b0});
    row(1'b1, CH_STAR);
    row(1'b0, "1");
    row_chk(1'b0, "7", 1'b1, '{KIND_ERROR, 8'h00, 4'd0, 1'b0, 1'b0});
    row(1'b1, CH_STAR);
    row(1'b0, "1");
    row(1'b0, CH_CR);
    row_chk(1'b0, "x", 1'b1, '{KIND_ERROR, 8'h00, 4'd0, 1'b0, 1'b0});
    row(1'b1, CH_STAR);
    row(1'b0, "9");
    row(1'b0, CH_CR);
    row(1'b0, CH_LF);
    row_chk(1'b0, "#", 1'b0, '0);
    row_chk(1'b0, CH_DOLLAR, 1'b0, '0);

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_q[i]) send_byte(directed_q[i].item, directed_q[i].chk);

    // random requests; loose noise bytes do not count toward the total
    while (random_bytes < RANDOM_ITEMS) begin
      if ($urandom_range(0, 9) == 0) calm_tx = ~calm_tx;
      if ($urandom_range(0, 19) == 0)
        repeat ($urandom_range(1, 4)) send_byte('{1'b0, 8'($urandom_range(0, 255))}, '0);
      compose_request();
      foreach (burst_q[i]) send_byte(burst_q[i], '0);
      random_bytes += burst_q.size();
    end
    req_valid <= 1'b0;

    // let the last results out, then give a stray one time to show
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("PASS resp_bulk_array_parser_top");
    end else begin
      $display("FAIL resp_bulk_array_parser_top");
    end
    $finish;
  end

endmodule
